// ===== sv/psft_pkg.sv =====
// Shared constants and a helper function for the pointing stick frame tracker.
`default_nettype none
package psft_pkg;

  // Widths of the shared serial divider and square root units.
  localparam int unsigned DIV_NUM_W = 17;
  localparam int unsigned DIV_DEN_W = 9;
  localparam int unsigned SQRT_IN_W = 17;
  localparam int unsigned ROOT_W    = 9;

  // Signal processing constants.
  localparam logic [11:0] LEVEL_FLOOR = 12'd1000;
  localparam logic [11:0] LEVEL_RAMP  = 12'd100;
  localparam logic [8:0]  DEAD_ZONE   = 9'd24;
  localparam logic [7:0]  CENTRE_LO   = 8'd104;
  localparam logic [7:0]  CENTRE_HI   = 8'd152;

  // Operation codes on the input channel.
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Wheel codes as stored in the pending register.
  localparam logic [1:0] WHEEL_NONE = 2'd0;
  localparam logic [1:0] WHEEL_UP   = 2'd1;
  localparam logic [1:0] WHEEL_DOWN = 2'd3;

  // Report divisor for each speed setting: 104 times (4 minus resolution).
  function automatic logic [DIV_DEN_W-1:0] report_gain(input logic [1:0] res);
    logic [DIV_DEN_W-1:0] g;
    case (res)
      2'd0:    g = 9'd416;
      2'd1:    g = 9'd312;
      2'd2:    g = 9'd208;
      default: g = 9'd104;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/psft_in_if.sv =====
// Channel interfaces for input items and result items.
`default_nettype none
interface psft_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] octet;
  logic       wheel_up_key;
  logic       wheel_down_key;
  logic [4:0] button_bits;

  modport source(output valid, op, octet, wheel_up_key, wheel_down_key, button_bits,
                 input ready);
  modport sink(input valid, op, octet, wheel_up_key, wheel_down_key, button_bits,
               output ready);
endinterface

interface psft_out_if;
  logic              valid;
  logic              ready;
  logic              sample_done;
  logic              touched;
  logic              report_valid;
  logic [4:0]        report_buttons;
  logic signed [7:0] report_dx;
  logic signed [7:0] report_dy;
  logic signed [1:0] report_wheel;

  modport source(output valid, sample_done, touched, report_valid, report_buttons,
                 report_dx, report_dy, report_wheel, input ready);
  modport sink(input valid, sample_done, touched, report_valid, report_buttons,
               report_dx, report_dy, report_wheel, output ready);
endinterface
`default_nettype wire

// ===== sv/pointing_stick_frame_tracker_top.sv =====
// Top level of the pointing stick frame tracker: frame parsing and sample sequencer.
//
//   channel  direction  transaction
//   in_ch    sink       one sensor byte or one report request
//   out_ch   source     one result for every input transaction
//   cfg_*    write      resolution register, taken at any cycle with cfg_we high
//
// A byte that does not complete a frame goes straight to the output step; a request
// passes the report compare, after two divisions of the accumulators while touched. A
// completing byte walks the level, peak, touch, wheel, square root and accumulate steps,
// with two divisions for motion and up to three more when the peak rises and decays.
// Reset is synchronous and clears all tracking state. One item is in work at a time; a
// stalled output holds the sequencer in its last step until the output register frees.
`default_nettype none
module pointing_stick_frame_tracker_top #(
  parameter int unsigned TOUCH_SAMPLES = 12
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  psft_in_if.sink         in_ch,
  psft_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);
  localparam int unsigned TC_W = $clog2(TOUCH_SAMPLES + 1);
  localparam int unsigned NW   = psft_pkg::DIV_NUM_W;
  localparam int unsigned DW   = psft_pkg::DIV_DEN_W;
  localparam int unsigned RW   = psft_pkg::ROOT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_PEAK, S_THR1, S_TOUCH, S_DECAY, S_THR2, S_WHEEL,
    S_SQRT, S_MX, S_MY, S_SQ, S_RX, S_RY, S_REP, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       res_r;
  logic [2:0]       bidx_r, bidx_nxt;
  logic [11:0]      ftouch_r, ftouch_nxt;
  logic [7:0]       fx_r, fx_nxt, fy_r, fy_nxt;
  logic [11:0]      filt_r, filt_nxt, thr_r, thr_nxt, peak_r, peak_nxt, ceil_r, ceil_nxt;
  logic [TC_W-1:0]  tcnt_r, tcnt_nxt;
  logic [7:0]       cx_r, cx_nxt, cy_r, cy_nxt, lx_r, lx_nxt, ly_r, ly_nxt;
  logic [15:0]      accx_r, accx_nxt, accy_r, accy_nxt;
  logic [1:0]       wpend_r, wpend_nxt;
  logic [28:0]      lrep_r, lrep_nxt;
  logic             up_r, up_nxt, down_r, down_nxt;
  logic [4:0]       btn_r, btn_nxt;
  logic [7:0]       ax_r, ax_nxt, ay_r, ay_nxt;
  logic             nx_r, nx_nxt, ny_r, ny_nxt;
  logic [RW-1:0]    root_r, root_nxt;
  logic [7:0]       mqx_r, mqx_nxt, mqy_r, mqy_nxt;
  logic [DW-1:0]    qx_r, qx_nxt, rx_r, rx_nxt;
  logic             rdone_r, rdone_nxt, rvalid_r, rvalid_nxt;
  logic [4:0]       rbtn_r, rbtn_nxt;
  logic [7:0]       rdx_r, rdx_nxt, rdy_r, rdy_nxt;
  logic [1:0]       rwh_r, rwh_nxt;
  logic             ov_r, ov_nxt;
  logic             od_r, ot_r, orv_r;
  logic [4:0]       ob_r;
  logic [7:0]       odx_r, ody_r;
  logic [1:0]       ow_r;

  logic             div_start, div_done;
  logic [NW-1:0]    div_num, div_quot;
  logic [DW-1:0]    div_den, div_rem;
  logic             sq_start, sq_done;
  logic [NW-1:0]    sq_val;
  logic [RW-1:0]    sq_root;

  logic             touched_now;
  logic [2:0]       idx;
  logic [11:0]      t1, t2, p2;
  logic [12:0]      lim;
  logic [7:0]       dax, day;
  logic [15:0]      msq_x, msq_y;
  logic [16:0]      absa;
  logic [8:0]       rsub;
  logic [DW-1:0]    gain;
  logic [7:0]       dq, dq2, w8;
  logic [28:0]      rep;
  logic             load_out;

  psft_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  psft_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(sq_val),
    .done(sq_done), .root(sq_root)
  );

  assign touched_now = (filt_r < thr_r) && (tcnt_r >= TC_W'(TOUCH_SAMPLES));
  assign in_ch.ready = (state_r == S_IDLE);
  assign load_out    = (state_r == S_OUT) && (!ov_r || out_ch.ready);

  // Sequencer: parses bytes, then walks the sample or report steps.
  always_comb begin
    state_nxt = state_r;
    bidx_nxt = bidx_r; ftouch_nxt = ftouch_r; fx_nxt = fx_r; fy_nxt = fy_r;
    filt_nxt = filt_r; thr_nxt = thr_r; peak_nxt = peak_r; ceil_nxt = ceil_r;
    tcnt_nxt = tcnt_r; cx_nxt = cx_r; cy_nxt = cy_r; lx_nxt = lx_r; ly_nxt = ly_r;
    accx_nxt = accx_r; accy_nxt = accy_r; wpend_nxt = wpend_r; lrep_nxt = lrep_r;
    up_nxt = up_r; down_nxt = down_r; btn_nxt = btn_r;
    ax_nxt = ax_r; ay_nxt = ay_r; nx_nxt = nx_r; ny_nxt = ny_r; root_nxt = root_r;
    mqx_nxt = mqx_r; mqy_nxt = mqy_r; qx_nxt = qx_r; rx_nxt = rx_r;
    rdone_nxt = rdone_r; rvalid_nxt = rvalid_r; rbtn_nxt = rbtn_r;
    rdx_nxt = rdx_r; rdy_nxt = rdy_r; rwh_nxt = rwh_r;
    div_start = 1'b0; div_num = '0; div_den = '0;
    sq_start = 1'b0; sq_val = '0;
    idx = in_ch.octet[7] ? 3'd1 : bidx_r;
    t1 = (ftouch_r < psft_pkg::LEVEL_FLOOR) ? psft_pkg::LEVEL_FLOOR : ftouch_r;
    lim = {1'b0, ceil_r} + {1'b0, psft_pkg::LEVEL_RAMP};
    t2 = (lim < {1'b0, t1}) ? lim[11:0] : t1;
    p2 = (div_quot[11:0] < filt_r) ? filt_r : div_quot[11:0];
    dax = (fx_r < cx_r) ? (cx_r - fx_r) : (fx_r - cx_r);
    day = (fy_r < cy_r) ? (cy_r - fy_r) : (fy_r - cy_r);
    rsub = root_r - psft_pkg::DEAD_ZONE;
    msq_x = mqx_r * mqx_r;
    msq_y = mqy_r * mqy_r;
    gain = psft_pkg::report_gain(res_r);
    absa = ny_r ? (17'd0 - {accy_r[15], accy_r}) : {accy_r[15], accy_r};
    dq = nx_r ? (8'd0 - qx_r[7:0]) : qx_r[7:0];
    dq2 = ny_r ? (8'd0 - div_quot[7:0]) : div_quot[7:0];
    w8 = (wpend_r == psft_pkg::WHEEL_DOWN) ? 8'hFF : {6'd0, wpend_r};
    rep = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          up_nxt = in_ch.wheel_up_key;
          down_nxt = in_ch.wheel_down_key;
          btn_nxt = in_ch.button_bits;
          rdone_nxt = 1'b0; rvalid_nxt = 1'b0; rbtn_nxt = '0;
          rdx_nxt = '0; rdy_nxt = '0; rwh_nxt = '0;
          state_nxt = S_OUT;
          if (in_ch.op == psft_pkg::OP_BYTE) begin
            case (idx)
              3'd1: begin
                ftouch_nxt = {in_ch.octet[6:2], 7'd0};
                fy_nxt = {in_ch.octet[1], 7'd0};
                fx_nxt = {in_ch.octet[0], 7'd0};
                bidx_nxt = 3'd2;
              end
              3'd2: begin
                ftouch_nxt = ftouch_r | {4'd0, in_ch.octet};
                bidx_nxt = 3'd3;
              end
              3'd3: begin
                fx_nxt = fx_r | in_ch.octet;
                bidx_nxt = 3'd4;
              end
              3'd4: begin
                fy_nxt = fy_r | in_ch.octet;
                bidx_nxt = 3'd0;
                state_nxt = S_LEVEL;
              end
              default: bidx_nxt = 3'd0;
            endcase
          end else if (touched_now) begin
            nx_nxt = accx_r[15];
            ny_nxt = accy_r[15];
            div_start = 1'b1;
            div_num = accx_r[15] ? (17'd0 - {1'b1, accx_r}) : {1'b0, accx_r};
            div_den = gain;
            state_nxt = S_RX;
          end else begin
            state_nxt = S_REP;
          end
        end
      end
      // Clamp, ramp limit and low-pass filter of the touch level.
      S_LEVEL: begin
        if (ceil_r < t1) begin
          ceil_nxt = t2;
          filt_nxt = filt_r - {2'd0, filt_r[11:2]} + {2'd0, t2[11:2]};
        end else begin
          filt_nxt = filt_r - {2'd0, filt_r[11:2]} + {2'd0, t1[11:2]};
        end
        state_nxt = S_PEAK;
      end
      S_PEAK: begin
        state_nxt = S_TOUCH;
        if (peak_r < filt_r) begin
          peak_nxt = filt_r;
          div_start = 1'b1;
          div_num = NW'(filt_r * 15'd5);
          div_den = DW'(7);
          state_nxt = S_THR1;
        end
      end
      S_THR1: begin
        if (div_done) begin
          thr_nxt = div_quot[11:0];
          state_nxt = S_TOUCH;
        end
      end
      // Touch debounce, and centre recalibration when idle and still.
      S_TOUCH: begin
        state_nxt = S_WHEEL;
        if (filt_r < thr_r) begin
          if (tcnt_r < TC_W'(TOUCH_SAMPLES)) tcnt_nxt = tcnt_r + 1'b1;
        end else begin
          tcnt_nxt = '0;
          if (((fx_r > psft_pkg::CENTRE_LO && fx_r < psft_pkg::CENTRE_HI &&
                fy_r > psft_pkg::CENTRE_LO && fy_r < psft_pkg::CENTRE_HI) ||
               (cx_r == 8'd0 && cy_r == 8'd0)) && fx_r == lx_r && fy_r == ly_r) begin
            cx_nxt = fx_r;
            cy_nxt = fy_r;
            if (tcnt_r == TC_W'(TOUCH_SAMPLES)) begin
              div_start = 1'b1;
              div_num = NW'({peak_r, 3'd0});
              div_den = DW'(9);
              state_nxt = S_DECAY;
            end
          end
        end
      end
      S_DECAY: begin
        if (div_done) begin
          peak_nxt = p2;
          div_start = 1'b1;
          div_num = NW'(p2 * 15'd5);
          div_den = DW'(7);
          state_nxt = S_THR2;
        end
      end
      S_THR2: begin
        if (div_done) begin
          thr_nxt = div_quot[11:0];
          state_nxt = S_WHEEL;
        end
      end
      // Wheel sampling and the radial distance from the centre.
      S_WHEEL: begin
        if (touched_now) begin
          wpend_nxt = up_r ? psft_pkg::WHEEL_UP :
                      (down_r ? psft_pkg::WHEEL_DOWN : psft_pkg::WHEEL_NONE);
        end
        nx_nxt = fx_r < cx_r;
        ny_nxt = fy_r < cy_r;
        ax_nxt = dax;
        ay_nxt = day;
        sq_start = 1'b1;
        sq_val = NW'(dax * dax) + NW'(day * day);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          root_nxt = sq_root;
          if (sq_root > psft_pkg::DEAD_ZONE) begin
            div_start = 1'b1;
            div_num = NW'(ax_r * (sq_root - psft_pkg::DEAD_ZONE));
            div_den = sq_root;
            state_nxt = S_MX;
          end else begin
            mqx_nxt = '0;
            mqy_nxt = '0;
            state_nxt = S_SQ;
          end
        end
      end
      S_MX: begin
        if (div_done) begin
          mqx_nxt = div_quot[7:0];
          div_start = 1'b1;
          div_num = NW'(ay_r * rsub);
          div_den = root_r;
          state_nxt = S_MY;
        end
      end
      S_MY: begin
        if (div_done) begin
          mqy_nxt = div_quot[7:0];
          state_nxt = S_SQ;
        end
      end
      // Squared motion goes into the wrapping accumulators.
      S_SQ: begin
        accx_nxt = nx_r ? (accx_r - msq_x) : (accx_r + msq_x);
        accy_nxt = ny_r ? (accy_r - msq_y) : (accy_r + msq_y);
        lx_nxt = fx_r;
        ly_nxt = fy_r;
        rdone_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_RX: begin
        if (div_done) begin
          qx_nxt = div_quot[DW-1:0];
          rx_nxt = div_rem;
          div_start = 1'b1;
          div_num = absa;
          div_den = gain;
          state_nxt = S_RY;
        end
      end
      S_RY: begin
        if (div_done) begin
          rdx_nxt = dq;
          rdy_nxt = dq2;
          accx_nxt = nx_r ? (16'd0 - {7'd0, rx_r}) : {7'd0, rx_r};
          accy_nxt = ny_r ? (16'd0 - {7'd0, div_rem}) : {7'd0, div_rem};
          rbtn_nxt = btn_r;
          rwh_nxt = wpend_r;
          wpend_nxt = psft_pkg::WHEEL_NONE;
          state_nxt = S_REP;
        end
      end
      // Compare against the last sent report.
      S_REP: begin
        rep = {(rwh_r == psft_pkg::WHEEL_DOWN) ? 8'hFF : {6'd0, rwh_r},
               rdy_r, rdx_r, rbtn_r};
        if (rdx_r != 8'd0 || rdy_r != 8'd0 || rwh_r != 2'd0 || rep != lrep_r) begin
          rvalid_nxt = 1'b1;
          lrep_nxt = rep;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (w8 == 8'd0 && rep == 29'd0) rep = '0;
  end

  assign ov_nxt = load_out ? 1'b1 : (ov_r && !out_ch.ready);

  // State registers, configuration register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r <= '0;
      bidx_r <= '0; ftouch_r <= '0; fx_r <= '0; fy_r <= '0;
      filt_r <= '0; thr_r <= '0; peak_r <= '0; ceil_r <= '0; tcnt_r <= '0;
      cx_r <= '0; cy_r <= '0; lx_r <= '0; ly_r <= '0;
      accx_r <= '0; accy_r <= '0; wpend_r <= '0; lrep_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) res_r <= cfg_wdata;
      bidx_r <= bidx_nxt; ftouch_r <= ftouch_nxt; fx_r <= fx_nxt; fy_r <= fy_nxt;
      filt_r <= filt_nxt; thr_r <= thr_nxt; peak_r <= peak_nxt; ceil_r <= ceil_nxt;
      tcnt_r <= tcnt_nxt;
      cx_r <= cx_nxt; cy_r <= cy_nxt; lx_r <= lx_nxt; ly_r <= ly_nxt;
      accx_r <= accx_nxt; accy_r <= accy_nxt; wpend_r <= wpend_nxt; lrep_r <= lrep_nxt;
      ov_r <= ov_nxt;
    end
    up_r <= up_nxt; down_r <= down_nxt; btn_r <= btn_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt; root_r <= root_nxt;
    mqx_r <= mqx_nxt; mqy_r <= mqy_nxt; qx_r <= qx_nxt; rx_r <= rx_nxt;
    rdone_r <= rdone_nxt; rvalid_r <= rvalid_nxt; rbtn_r <= rbtn_nxt;
    rdx_r <= rdx_nxt; rdy_r <= rdy_nxt; rwh_r <= rwh_nxt;
    if (load_out) begin
      od_r <= rdone_r;
      ot_r <= touched_now;
      orv_r <= rvalid_r;
      ob_r <= rbtn_r;
      odx_r <= rdx_r;
      ody_r <= rdy_r;
      ow_r <= rwh_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.sample_done    = od_r;
  assign out_ch.touched        = ot_r;
  assign out_ch.report_valid   = orv_r;
  assign out_ch.report_buttons = ob_r;
  assign out_ch.report_dx      = odx_r;
  assign out_ch.report_dy      = ody_r;
  assign out_ch.report_wheel   = ow_r;
endmodule
`default_nettype wire

// ===== sv/psft_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module psft_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [psft_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [psft_pkg::DIV_DEN_W-1:0]  den,
  output logic                                 done,
  output logic [psft_pkg::DIV_NUM_W-1:0]       quot,
  output logic [psft_pkg::DIV_DEN_W-1:0]       rem
);
  localparam int unsigned NW = psft_pkg::DIV_NUM_W;
  localparam int unsigned DW = psft_pkg::DIV_DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] sh_r, sh_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One shift and trial subtract per cycle; quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem_r, sh_r[NW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      sh_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = sh_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ===== sv/psft_sqrt.sv =====
// Floor square root that takes one bit pair of the radicand per cycle.
`default_nettype none
module psft_sqrt (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [psft_pkg::SQRT_IN_W-1:0]  val,
  output logic                                 done,
  output logic [psft_pkg::ROOT_W-1:0]          root
);
  localparam int unsigned RW = psft_pkg::ROOT_W;
  localparam int unsigned PW = 2 * RW;
  localparam int unsigned MW = RW + 3;
  localparam int unsigned CW = $clog2(RW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] sh_r, sh_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [MW-1:0] acc;
  logic [MW-1:0] test;

  // Bring down two radicand bits, then try to append a one to the root.
  always_comb begin
    acc      = {rem_r[MW-3:0], sh_r[PW-1:PW-2]};
    test     = {1'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(RW);
      sh_nxt   = PW'(val);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[PW-3:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (acc >= test) begin
        rem_nxt  = acc - test;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = acc;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pointing stick frame tracker top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int unsigned TOUCH_SAMPLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 4000000;

  typedef struct packed {
    logic       op;
    logic [7:0] octet;
    logic       up;
    logic       down;
    logic [4:0] btn;
  } stim_t;

  typedef struct packed {
    logic       sample_done;
    logic       touched;
    logic       report_valid;
    logic [4:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [1:0] wheel;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  psft_in_if  in_ch();
  psft_out_if out_ch();

  pointing_stick_frame_tracker_top #(.TOUCH_SAMPLES(TOUCH_SAMPLES)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Tracker state mirrored at the block's widths.
  logic [1:0]  speed;
  logic [2:0]  byte_pos;
  logic [11:0] f_touch;
  logic [7:0]  f_x, f_y;
  logic [11:0] lvl_filt, lvl_thr, lvl_peak, lvl_ceil;
  logic [3:0]  below_cnt;
  logic [7:0]  ctr_x, ctr_y, prev_x, prev_y;
  logic [15:0] acc_x, acc_y;
  logic [1:0]  wheel_hold;
  logic [28:0] sent_report;

  result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned reports_sent = 0;
  int unsigned touched_seen = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned total_items = 0;

  function automatic bit touch_active();
    return lvl_filt < lvl_thr && below_cnt >= TOUCH_SAMPLES;
  endfunction

  function automatic int unsigned floor_root(int unsigned n);
    int unsigned root;
    int unsigned b;
    root = 0;
    b = 1 << 16;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic int unsigned off_centre(logic [7:0] v);
    return (v < 128) ? 128 - v : v - 128;
  endfunction

  // Level filtering, touch detection, recentering and motion accumulation.
  task automatic track_sample(input logic up, input logic down);
    int unsigned lvl, lim, ax, ay, r, mx, my;
    bit nx, ny;
    lvl = f_touch;
    if (lvl < psft_pkg::LEVEL_FLOOR) lvl = psft_pkg::LEVEL_FLOOR;
    if (lvl_ceil < lvl) begin
      lim = lvl_ceil + psft_pkg::LEVEL_RAMP;
      if (lim < lvl) lvl = lim;
      lvl_ceil = 12'(lvl);
    end
    lvl_filt = 12'(lvl_filt - (lvl_filt >> 2) + (lvl >> 2));
    if (lvl_peak < lvl_filt) begin
      lvl_peak = lvl_filt;
      lvl_thr = 12'((32'(lvl_peak) * 5) / 7);
    end
    if (lvl_filt < lvl_thr) begin
      if (below_cnt < TOUCH_SAMPLES) below_cnt++;
    end else begin
      if ((off_centre(f_x) < psft_pkg::DEAD_ZONE && off_centre(f_y) < psft_pkg::DEAD_ZONE) ||
          (ctr_x == 0 && ctr_y == 0)) begin
        if (f_x == prev_x && f_y == prev_y) begin
          ctr_x = f_x;
          ctr_y = f_y;
          if (below_cnt == TOUCH_SAMPLES) begin
            lvl_peak = 12'((32'(lvl_peak) * 8) / 9);
            if (lvl_peak < lvl_filt) lvl_peak = lvl_filt;
            lvl_thr = 12'((32'(lvl_peak) * 5) / 7);
          end
        end
      end
      below_cnt = '0;
    end
    if (touch_active())
      wheel_hold = up ? psft_pkg::WHEEL_UP :
                   (down ? psft_pkg::WHEEL_DOWN : psft_pkg::WHEEL_NONE);
    nx = f_x < ctr_x;
    ny = f_y < ctr_y;
    ax = nx ? ctr_x - f_x : f_x - ctr_x;
    ay = ny ? ctr_y - f_y : f_y - ctr_y;
    r = floor_root(ax * ax + ay * ay);
    mx = 0;
    my = 0;
    if (r > psft_pkg::DEAD_ZONE) begin
      mx = ax * (r - psft_pkg::DEAD_ZONE) / r;
      my = ay * (r - psft_pkg::DEAD_ZONE) / r;
      mx *= mx;
      my *= my;
    end
    acc_x = nx ? acc_x - 16'(mx) : acc_x + 16'(mx);
    acc_y = ny ? acc_y - 16'(my) : acc_y + 16'(my);
    prev_x = f_x;
    prev_y = f_y;
  endtask

  // Computes the result of one input transaction and advances the mirrored state.
  task automatic predict_result(input stim_t s, output result_t res);
    int g, a, b, qx, qy;
    logic [7:0] w8;
    logic [28:0] rep;
    res = '0;
    if (s.op == psft_pkg::OP_BYTE) begin
      if (s.octet[7]) byte_pos = 3'd1;
      case (byte_pos)
        3'd1: begin
          f_touch = 12'(s.octet & 8'h7c) << 5;
          f_y = {s.octet[1], 7'd0};
          f_x = {s.octet[0], 7'd0};
          byte_pos = 3'd2;
        end
        3'd2: begin
          f_touch = f_touch | 12'(s.octet);
          byte_pos = 3'd3;
        end
        3'd3: begin
          f_x = f_x | s.octet;
          byte_pos = 3'd4;
        end
        3'd4: begin
          f_y = f_y | s.octet;
          byte_pos = 3'd0;
          track_sample(s.up, s.down);
          res.sample_done = 1'b1;
        end
        default: byte_pos = 3'd0;
      endcase
    end else begin
      if (touch_active()) begin
        g = 104 * (4 - int'(speed));
        a = int'($signed(acc_x));
        b = int'($signed(acc_y));
        qx = a / g;
        qy = b / g;
        acc_x = 16'(a - g * qx);
        acc_y = 16'(b - g * qy);
        res.buttons = s.btn;
        res.dx = 8'(qx);
        res.dy = 8'(qy);
        res.wheel = wheel_hold;
        wheel_hold = psft_pkg::WHEEL_NONE;
      end
      w8 = (res.wheel == psft_pkg::WHEEL_DOWN) ? 8'hff : {6'd0, res.wheel};
      rep = {w8, res.dy, res.dx, res.buttons};
      if (res.dx != 0 || res.dy != 0 || res.wheel != 0 || rep != sent_report) begin
        res.report_valid = 1'b1;
        sent_report = rep;
      end
    end
    res.touched = touch_active();
  endtask

  task automatic clear_model();
    speed = '0; byte_pos = '0; f_touch = '0; f_x = '0; f_y = '0;
    lvl_filt = '0; lvl_thr = '0; lvl_peak = '0; lvl_ceil = '0; below_cnt = '0;
    ctr_x = '0; ctr_y = '0; prev_x = '0; prev_y = '0; acc_x = '0; acc_y = '0;
    wheel_hold = '0; sent_report = '0;
  endtask

  // Input channel drive, changed on the falling edge.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = psft_pkg::OP_BYTE;
    in_ch.octet = 8'd0;
    in_ch.wheel_up_key = 1'b0;
    in_ch.wheel_down_key = 1'b0;
    in_ch.button_bits = 5'd0;
    out_ch.ready = 1'b0;
  end

  // Sends one transaction and records its expected result at the accepting edge.
  task automatic send_item(input stim_t s, input bit check_given, input result_t given);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= s.op;
    in_ch.octet <= s.octet;
    in_ch.wheel_up_key <= s.up;
    in_ch.wheel_down_key <= s.down;
    in_ch.button_bits <= s.btn;
    do @(posedge clk); while (!in_ch.ready);
    predict_result(s, res);
    if (check_given && res != given) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row predicted %h, typed %h", res, given);
    end
    expected_results.push_back(res);
    total_items++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic up, input logic down);
    send_item('{psft_pkg::OP_BYTE, b, up, down, 5'd0}, 1'b0, '0);
  endtask

  // One frame; touch level, x and y encoded across the four bytes.
  task automatic send_frame(input logic [11:0] lvl, input logic [7:0] x,
                            input logic [7:0] y, input logic up, input logic down);
    send_byte({1'b1, lvl[11:7], y[7], x[7]}, 1'b0, 1'b0);
    send_byte({1'b0, lvl[6:0]}, 1'b0, 1'b0);
    send_byte({1'b0, x[6:0]}, 1'b0, 1'b0);
    send_byte({1'b0, y[6:0]}, up, down);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_speed(input logic [1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    speed = v;
  endtask

  // Result checking at the rising edge.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.sample_done, out_ch.touched, out_ch.report_valid,
              out_ch.report_buttons, out_ch.report_dx, out_ch.report_dy,
              out_ch.report_wheel};
      results_seen++;
      if (got.report_valid) reports_sent++;
      if (got.touched) touched_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result %0d: expected done=%b t=%b v=%b b=%h dx=%h dy=%h w=%h, ",
                   results_seen, want.sample_done, want.touched, want.report_valid,
                   want.buttons, want.dx, want.dy, want.wheel);
            $display("got done=%b t=%b v=%b b=%h dx=%h dy=%h w=%h",
                     got.sample_done, got.touched, got.report_valid, got.buttons,
                     got.dx, got.dy, got.wheel);
          end
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Directed rows: ignored bytes, extremes and requests after reset.
  stim_t   dir_stim[12];
  bit      dir_typed[12];
  result_t dir_res[12];

  // A touch-and-drag session with random content.
  task automatic random_session();
    int n;
    logic [7:0] cx, cy, dxv, dyv;
    cx = 8'($urandom_range(110, 146));
    cy = 8'($urandom_range(110, 146));
    // Still, untouched frames at a high level settle the centre and peak.
    repeat ($urandom_range(2, 5))
      send_frame(12'($urandom_range(3000, 4095)), cx, cy, 1'b0, 1'b0);
    // A low level for long enough to count as touch, with random drags and requests.
    n = $urandom_range(10, 22);
    for (int k = 0; k < n; k++) begin
      dxv = 8'($urandom_range(0, 255));
      dyv = 8'($urandom_range(0, 255));
      if ($urandom_range(3) == 0) begin dxv = cx; dyv = cy; end
      send_frame(12'($urandom_range(0, 1400)), dxv, dyv, 1'($urandom), 1'($urandom));
      if ($urandom_range(2) == 0)
        send_item('{psft_pkg::OP_REPORT, 8'($urandom), 1'($urandom), 1'($urandom),
                    5'($urandom)}, 1'b0, '0);
    end
    // Release.
    repeat ($urandom_range(1, 4))
      send_frame(12'($urandom_range(2500, 4095)), cx, cy, 1'b0, 1'b0);
  endtask

  task automatic random_noise();
    stim_t s;
    s = stim_t'(16'($urandom));
    if (s.op == psft_pkg::OP_BYTE && $urandom_range(1) == 1) s.octet[7] = 1'b1;
    send_item(s, 1'b0, '0);
  endtask

  int unsigned sent_items;

  initial begin
    clear_model();
    dir_stim[0] = '{psft_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 5'd0};
    dir_typed[0] = 1'b1; dir_res[0] = '0;
    dir_stim[1] = '{psft_pkg::OP_BYTE, 8'h7f, 1'b1, 1'b1, 5'd31};
    dir_typed[1] = 1'b1; dir_res[1] = '0;
    dir_stim[2] = '{psft_pkg::OP_REPORT, 8'hff, 1'b1, 1'b1, 5'd31};
    dir_typed[2] = 1'b1; dir_res[2] = '0;
    dir_stim[3] = '{psft_pkg::OP_BYTE, 8'hff, 1'b0, 1'b0, 5'd0};
    dir_typed[3] = 1'b1; dir_res[3] = '0;
    dir_stim[4] = '{psft_pkg::OP_BYTE, 8'h80, 1'b0, 1'b0, 5'd0};
    dir_typed[4] = 1'b1; dir_res[4] = '0;
    dir_stim[5] = '{psft_pkg::OP_BYTE, 8'h7f, 1'b0, 1'b0, 5'd0};
    dir_typed[5] = 1'b1; dir_res[5] = '0;
    dir_stim[6] = '{psft_pkg::OP_BYTE, 8'h7f, 1'b0, 1'b0, 5'd0};
    dir_typed[6] = 1'b1; dir_res[6] = '0;
    dir_stim[7] = '{psft_pkg::OP_BYTE, 8'h7f, 1'b1, 1'b0, 5'd0};
    dir_typed[7] = 1'b0; dir_res[7] = '0;
    dir_stim[8] = '{psft_pkg::OP_BYTE, 8'h83, 1'b0, 1'b0, 5'd0};
    dir_typed[8] = 1'b1; dir_res[8] = '0;
    dir_stim[9] = '{psft_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 5'd0};
    dir_typed[9] = 1'b1; dir_res[9] = '0;
    dir_stim[10] = '{psft_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 5'd0};
    dir_typed[10] = 1'b1; dir_res[10] = '0;
    dir_stim[11] = '{psft_pkg::OP_BYTE, 8'h00, 1'b0, 1'b1, 5'd0};
    dir_typed[11] = 1'b0; dir_res[11] = '0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < 12; i++) send_item(dir_stim[i], dir_typed[i], dir_res[i]);
    // Frame restart part way through, then extreme deflections at every speed.
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    for (int sp = 3; sp >= 0; sp--) begin
      write_speed(2'(sp));
      send_frame(12'd4095, 8'd128, 8'd128, 1'b0, 1'b0);
      send_frame(12'd4095, 8'd128, 8'd128, 1'b0, 1'b0);
      repeat (14)
        send_frame(12'd0, sp[0] ? 8'd255 : 8'd0, sp[1] ? 8'd0 : 8'd255, 1'b1, 1'b0);
      send_item('{psft_pkg::OP_REPORT, 8'h00, 1'b0, 1'b0, 5'd31}, 1'b0, '0);
      send_item('{psft_pkg::OP_REPORT, 8'h00, 1'b0, 1'b0, 5'd31}, 1'b0, '0);
      send_frame(12'd0, 8'd128, 8'd128, 1'b0, 1'b1);
      send_item('{psft_pkg::OP_REPORT, 8'h00, 1'b0, 1'b0, 5'd0}, 1'b0, '0);
      send_frame(12'd4095, 8'd128, 8'd128, 1'b0, 1'b0);
    end

    // Random phases with three idling patterns and a speed change per phase.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 11 : 0;
      write_speed(2'($urandom_range(3)));
      sent_items = total_items + 400;
      while (total_items < sent_items) begin
        if ($urandom_range(9) < 8) begin
          random_session();
        end else begin
          repeat (10) random_noise();
        end
        if ($urandom_range(4) == 0) drain();
      end
    end
    write_speed(2'd0);
    write_speed(2'd3);
    drain();

    $display("Checked %0d results from %0d transactions: %0d sent reports, %0d touched.",
             results_seen, total_items, reports_sent, touched_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
